// ===== hdl/mhsa_pkg.sv =====
// Shared types and constants for the MinHash signature accumulator.
// No dependencies; imported by minhash_signature_accumulator.
`default_nettype none
package mhsa_pkg;

  localparam int unsigned DEF_NUM_PERMS = 16;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  // The FNV-1a 64-bit prime is 2^40 + 0x1B3.
  localparam int unsigned FNV_SHIFT = 40;
  localparam logic [8:0]  FNV_LOW   = 9'h1B3;

  localparam int unsigned MERS_BITS = 61;
  localparam logic [60:0] MERS_P    = {61{1'b1}};

  localparam logic [2:0] FUNC_BYTE  = 3'd0;
  localparam logic [2:0] FUNC_EMPTY = 3'd1;
  localparam logic [2:0] FUNC_SEED  = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [3:0]  seed_index;
    logic [60:0] seed_mult;
    logic [60:0] seed_add;
  } mhsa_in_t;

  typedef struct packed {
    logic [63:0] min_value;
    logic [3:0]  perm_index;
    logic        last_value;
  } mhsa_out_t;

endpackage
`default_nettype wire

// ===== hdl/minhash_signature_accumulator.sv =====
// MinHash signature accumulator top level: FNV-1a folding, per-permutation
// modular hashing with one shared 32x32 multiplier, and memory-held state.
// Depends on mhsa_pkg.
//
// Usage: items arrive on the in_ channel (valid/ready) as mhsa_in_t; each
// transfer carries one operation selected by func. Results leave on the out_
// channel as mhsa_out_t, only for a signature read.
// Sequencing:
//   element byte without end, seed load, clear and unused codes: accepted with no busy state.
//   element end (last byte or empty element): the base hash is reduced modulo
//   2^61-1, then each permutation reads its seed pair and minimum, forms a*x
//   through the shared 32x32 multiplier in four partial products, reduces
//   modulo 2^61-1, then adds b and writes the result back if it is lower.
//   signature read: NUM_PERMS results in turn, each read through the single read
//   port of the minimum memory and loaded into the output register before the next.
// Reset clears the running hash to the FNV offset basis and marks every
// minimum invalid, which reads as all ones; seed memories hold no reset
// value and must be loaded before use. A stalled receiver holds the current
// result in the output register; the readout waits, and the input side
// accepts the next transfer as soon as the last result has been registered.
`default_nettype none
module minhash_signature_accumulator
  import mhsa_pkg::*;
#(
  parameter int unsigned NUM_PERMS = DEF_NUM_PERMS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mhsa_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output mhsa_out_t      out_data
);

  localparam int unsigned PW = (NUM_PERMS > 1) ? $clog2(NUM_PERMS) : 1;
  localparam logic [PW-1:0] LAST_PERM = PW'(NUM_PERMS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_XRED = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_M0   = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_R1   = 4'd7;
  localparam logic [3:0] S_R2   = 4'd8;
  localparam logic [3:0] S_RRD  = 4'd9;
  localparam logic [3:0] S_RLD  = 4'd10;

  // Memories: seed pairs and minimums, one synchronous read port each.
  logic [60:0] mult_mem [NUM_PERMS];
  logic [60:0] add_mem  [NUM_PERMS];
  logic [63:0] min_mem  [NUM_PERMS];
  logic [NUM_PERMS-1:0] min_valid_r;

  logic [3:0]    state_r, state_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [63:0]   hash_r, hash_nxt;
  logic [63:0]   base_r, base_nxt;
  logic [60:0]   x_r, x_nxt;
  logic [121:0]  acc_r, acc_nxt;
  logic [60:0]   t_r, t_nxt;
  logic [60:0]   a_q_r, b_q_r;
  logic [63:0]   min_q_r;
  logic          minv_q_r;
  logic          out_valid_r, out_valid_nxt;
  mhsa_out_t     out_data_r, out_data_nxt;

  logic          in_fire, out_fire;
  logic          rd_en, min_we, seed_we, clr_all;
  logic [PW-1:0] seed_addr;
  logic [63:0]   hash_x, hash_fold;
  logic [61:0]   xr1, xr2;
  logic [60:0]   a_eff, b_eff;
  logic [31:0]   op_a, op_x;
  logic [63:0]   pp;
  logic [6:0]    pp_sh;
  logic [61:0]   s1, s2, hsum;
  logic [60:0]   hval;
  logic [63:0]   cur_min;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_fire  = out_valid_r && out_ready;

  // FNV-1a step: multiply by the prime as a shift plus a 9-bit product.
  assign hash_x    = hash_r ^ {56'd0, in_data.data_byte};
  assign hash_fold = (hash_x << FNV_SHIFT) + (hash_x * {55'd0, FNV_LOW});

  // Base hash reduced modulo p.
  assign xr1 = {1'b0, base_r[60:0]} + {59'd0, base_r[63:61]};
  assign xr2 = {1'b0, xr1[60:0]} + {61'd0, xr1[61]};

  // A seed equal to p acts as zero.
  assign a_eff = (a_q_r == MERS_P) ? 61'd0 : a_q_r;
  assign b_eff = (b_q_r == MERS_P) ? 61'd0 : b_q_r;

  // Shared multiplier: one 32x32 partial product per cycle.
  always_comb begin
    op_a  = a_eff[31:0];
    op_x  = x_r[31:0];
    pp_sh = 7'd0;
    case (state_r)
      S_M1: begin
        op_x  = {3'd0, x_r[60:32]};
        pp_sh = 7'd32;
      end
      S_M2: begin
        op_a  = {3'd0, a_eff[60:32]};
        pp_sh = 7'd32;
      end
      S_M3: begin
        op_a  = {3'd0, a_eff[60:32]};
        op_x  = {3'd0, x_r[60:32]};
        pp_sh = 7'd64;
      end
      default: begin
        pp_sh = 7'd0;
      end
    endcase
  end
  assign pp = {32'd0, op_a} * {32'd0, op_x};

  // Product reduction modulo p and final add of b.
  assign s1   = {1'b0, acc_r[60:0]} + {1'b0, acc_r[121:61]};
  assign s2   = {1'b0, s1[60:0]} + {61'd0, s1[61]};
  assign hsum = {1'b0, t_r} + {1'b0, b_eff};
  assign hval = (hsum >= {1'b0, MERS_P}) ? 61'(hsum - {1'b0, MERS_P}) : hsum[60:0];
  assign cur_min = minv_q_r ? min_q_r : {64{1'b1}};

  assign seed_addr = PW'(in_data.seed_index);
  assign seed_we   = in_fire && (in_data.func == FUNC_SEED) &&
                     (32'(in_data.seed_index) < NUM_PERMS);
  assign clr_all   = in_fire && (in_data.func == FUNC_CLEAR);
  assign min_we    = (state_r == S_R2) && ({3'd0, hval} < cur_min);
  assign rd_en     = (state_r == S_RD) ||
                     ((state_r == S_RRD) && (!out_valid_r || out_ready));

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    hash_nxt      = hash_r;
    base_nxt      = base_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.func)
            FUNC_BYTE: begin
              if (in_data.last_byte) begin
                base_nxt  = hash_fold;
                hash_nxt  = FNV_BASIS;
                state_nxt = S_XRED;
              end else begin
                hash_nxt = hash_fold;
              end
            end
            FUNC_EMPTY: begin
              base_nxt  = FNV_BASIS;
              state_nxt = S_XRED;
            end
            FUNC_READ: begin
              idx_nxt   = '0;
              state_nxt = S_RRD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_XRED: begin
        x_nxt     = (xr2 >= {1'b0, MERS_P}) ? 61'(xr2 - {1'b0, MERS_P}) : xr2[60:0];
        idx_nxt   = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        acc_nxt   = '0;
        state_nxt = S_M0;
      end
      S_M0, S_M1, S_M2, S_M3: begin
        acc_nxt   = acc_r + ({58'd0, pp} << pp_sh);
        state_nxt = (state_r == S_M3) ? S_R1 : 4'(state_r + 4'd1);
      end
      S_R1: begin
        t_nxt     = (s2 >= {1'b0, MERS_P}) ? 61'(s2 - {1'b0, MERS_P}) : s2[60:0];
        state_nxt = S_R2;
      end
      S_R2: begin
        if (idx_r == LAST_PERM) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + PW'(1);
          state_nxt = S_RD;
        end
      end
      S_RRD: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_RLD;
        end
      end
      S_RLD: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.min_value  = minv_q_r ? min_q_r : {64{1'b1}};
        out_data_nxt.perm_index = 4'(idx_r);
        out_data_nxt.last_value = (idx_r == LAST_PERM);
        if (idx_r == LAST_PERM) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + PW'(1);
          state_nxt = S_RRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hash_r      <= FNV_BASIS;
      out_valid_r <= 1'b0;
      min_valid_r <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      if (clr_all) begin
        min_valid_r <= '0;
      end else if (min_we) begin
        min_valid_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    x_r        <= x_nxt;
    acc_r      <= acc_nxt;
    t_r        <= t_nxt;
    out_data_r <= out_data_nxt;
  end

  // Seed memories.
  always_ff @(posedge clk) begin
    if (seed_we) begin
      mult_mem[seed_addr] <= in_data.seed_mult;
      add_mem[seed_addr]  <= in_data.seed_add;
    end
    if (rd_en) begin
      a_q_r <= mult_mem[idx_r];
      b_q_r <= add_mem[idx_r];
    end
  end

  // Minimum memory; each permutation is read in turn and written back when lower.
  always_ff @(posedge clk) begin
    if (min_we) begin
      min_mem[idx_r] <= {3'd0, hval};
    end
    if (rd_en) begin
      min_q_r  <= min_mem[idx_r];
      minv_q_r <= min_valid_r[idx_r];
    end
  end

  // The output register must be free whenever a readout result is loaded.
  a_rld_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RLD) |-> (!out_valid_r || $past(out_ready)))
    else $error("readout result would overwrite a pending result");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.func == FUNC_CLEAR)) |=> (min_valid_r == '0))
    else $error("clear left a minimum marked valid");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_value) |-> (out_data_r.perm_index == 4'(LAST_PERM)))
    else $error("last flag on the wrong permutation");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_R1) |-> ($past(state_r) == S_M3))
    else $error("reduction entered before the product was complete");

endmodule
`default_nettype wire

// ===== test/tb_minhash_signature_accumulator.sv =====
// Testbench for the MinHash signature accumulator: drives operations on the
// in_ channel and checks every readout against a cycle-free predictor.
// Depends on mhsa_pkg and minhash_signature_accumulator.
`timescale 1ns / 1ps
`default_nettype none
module tb_minhash_signature_accumulator;
  import mhsa_pkg::*;

  localparam int unsigned NPERM = DEF_NUM_PERMS;
  localparam logic [63:0] FNV_MULT = 64'd1099511628211;
  localparam logic [63:0] P64 = {3'b000, MERS_P};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  mhsa_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mhsa_out_t out_data;

  minhash_signature_accumulator #(.NUM_PERMS(NPERM)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Predictor state: its own copy of the hash, seeds and minimums.
  logic [63:0] fold_hash;
  logic [60:0] mult_seed [NPERM];
  logic [60:0] add_seed [NPERM];
  logic [63:0] perm_min [NPERM];
  mhsa_out_t   pending_mins [$];

  int  failures = 0;
  bit  sender_idle = 1'b1;   // random gaps on the input side
  bit  receiver_idle = 1'b1; // random stalls on the output side
  bit  hold_off = 1'b0;      // long receiver stall for back pressure

  // Reduction of any value modulo 2^61-1.
  function automatic logic [63:0] reduce_p(logic [127:0] v);
    logic [127:0] r;
    r = v;
    while (r > {64'd0, P64}) r = (r & {67'd0, MERS_P}) + (r >> MERS_BITS);
    if (r == {64'd0, P64}) r = '0;
    return r[63:0];
  endfunction

  // Fold one element's base hash into every permutation's minimum.
  function automatic void absorb(logic [63:0] base);
    logic [63:0] x, a, b, h;
    x = reduce_p({64'd0, base});
    for (int i = 0; i < NPERM; i++) begin
      a = reduce_p({67'd0, mult_seed[i]});
      b = reduce_p({67'd0, add_seed[i]});
      h = reduce_p(128'(a) * 128'(x) + 128'(b));
      if (h < perm_min[i]) perm_min[i] = h;
    end
  endfunction

  function automatic void predict(mhsa_in_t it);
    mhsa_out_t r;
    case (it.func)
      FUNC_BYTE: begin
        fold_hash = (fold_hash ^ {56'd0, it.data_byte}) * FNV_MULT;
        if (it.last_byte) begin
          absorb(fold_hash);
          fold_hash = FNV_BASIS;
        end
      end
      FUNC_EMPTY: absorb(FNV_BASIS);
      FUNC_SEED: if (it.seed_index < NPERM) begin
        mult_seed[it.seed_index] = it.seed_mult;
        add_seed[it.seed_index] = it.seed_add;
      end
      FUNC_READ: for (int i = 0; i < NPERM; i++) begin
        r.min_value = perm_min[i];
        r.perm_index = 4'(i);
        r.last_value = (i == NPERM - 1);
        pending_mins.insert(pending_mins.size(), r);
      end
      FUNC_CLEAR: for (int i = 0; i < NPERM; i++) perm_min[i] = '1;
      default: ;
    endcase
  endfunction

  // Offer one item, hold it until the transfer, then predict its effect.
  task automatic send_op(mhsa_in_t it);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(it);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic mhsa_in_t make_op(logic [2:0] f, logic [7:0] d = 8'd0,
                                       logic l = 1'b0);
    mhsa_in_t it;
    it = '0;
    it.func = f;
    it.data_byte = d;
    it.last_byte = l;
    it.seed_index = 4'($urandom);
    it.seed_mult = {29'($urandom), 32'($urandom)};
    it.seed_add = {29'($urandom), 32'($urandom)};
    return it;
  endfunction

  function automatic logic [60:0] rand61();
    case ($urandom_range(0, 5))
      0: return 61'd1;
      1: return MERS_P;        // equal to p, acts as zero
      2: return MERS_P - 61'd1;
      default: return {29'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic load_seed(logic [3:0] idx, logic [60:0] a, logic [60:0] b);
    mhsa_in_t it;
    it = make_op(FUNC_SEED);
    it.seed_index = idx;
    it.seed_mult = a;
    it.seed_add = b;
    send_op(it);
  endtask

  task automatic send_element(int len);
    for (int i = 0; i < len; i++)
      send_op(make_op(FUNC_BYTE, 8'($urandom), i == len - 1));
  endtask

  // Every result is compared with the oldest predicted minimum.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_mins.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        failures++;
      end else begin
        mhsa_out_t exp_r;
        exp_r = pending_mins.pop_front();
        if (out_data.min_value !== exp_r.min_value) begin
          $display("%0t: min_value expected %h actual %h", $time,
                   exp_r.min_value, out_data.min_value);
          failures++;
        end
        if (out_data.perm_index !== exp_r.perm_index) begin
          $display("%0t: perm_index expected %0d actual %0d", $time,
                   exp_r.perm_index, out_data.perm_index);
          failures++;
        end
        if (out_data.last_value !== exp_r.last_value) begin
          $display("%0t: last_value expected %0d actual %0d", $time,
                   exp_r.last_value, out_data.last_value);
          failures++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        for (stall = 0; stall < 400; stall++) @(posedge clk);
        hold_off = 1'b0;
      end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Directed: load all seeds, the first three with edge values, then hit each operation.
  task automatic test_directed();
    mhsa_in_t it;
    load_seed(4'd0, 61'd1, 61'd0);
    load_seed(4'd1, MERS_P, MERS_P);        // both reduce to zero
    load_seed(4'd2, MERS_P - 61'd1, MERS_P - 61'd1);
    for (int i = 3; i < NPERM; i++) load_seed(4'(i), rand61(), rand61());
    send_op(make_op(FUNC_READ));            // all ones before any element
    send_op(make_op(FUNC_EMPTY));
    send_op(make_op(FUNC_BYTE, 8'h00, 1'b0));
    send_op(make_op(FUNC_EMPTY));           // partial element survives
    send_op(make_op(FUNC_BYTE, 8'hFF, 1'b1));
    send_op(make_op(FUNC_BYTE, 8'hA5, 1'b1));
    it = make_op(FUNC_SEED);
    it.seed_index = 4'd15;
    it.seed_mult = '1;
    it.seed_add = '0;
    send_op(it);
    for (int f = 5; f < 8; f++) send_op(make_op(3'(f), 8'hFF, 1'b1));
    send_op(make_op(FUNC_READ));
    send_op(make_op(FUNC_CLEAR));
    send_op(make_op(FUNC_READ));
  endtask

  // Back pressure: queue reads behind a long receiver stall.
  task automatic test_backpressure();
    hold_off = 1'b1;
    send_element(3);
    for (int i = 0; i < 4; i++) send_op(make_op(FUNC_READ));
  endtask

  // Random: mostly well-formed elements with occasional other operations.
  task automatic test_random(int count, bit with_gaps);
    int sent;
    int pick;
    int len;
    sender_idle = with_gaps;
    receiver_idle = with_gaps;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = $urandom_range(1, 6);
        send_element(len);
        sent += len;
      end else begin
        if (pick < 70) send_op(make_op(FUNC_EMPTY));
        else if (pick < 78) load_seed(4'($urandom), rand61(), rand61());
        else if (pick < 90) send_op(make_op(FUNC_READ));
        else if (pick < 94) send_op(make_op(FUNC_CLEAR));
        else send_op(make_op(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom)));
        sent++;
      end
    end
    send_op(make_op(FUNC_READ));
  endtask

  task automatic drain();
    go_idle();
    while (pending_mins.size() != 0) @(posedge clk);
    repeat (8 * NPERM) @(posedge clk);
  endtask

  initial begin
    fold_hash = FNV_BASIS;
    for (int i = 0; i < NPERM; i++) begin
      mult_seed[i] = '0;
      add_seed[i] = '0;
      perm_min[i] = '1;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(340, 1'b1);
    test_random(60, 1'b0);   // closing stretch without idling
    drain();
    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Worst case is far below this limit.
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/mhsa_pkg.sv
hdl/minhash_signature_accumulator.sv
test/tb_minhash_signature_accumulator.sv
